// ===== src/isotp_rc_pkg.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector package
// Shared codes, register layout and beat types of the response collector.
// ----------------------------------------------------------------------------
package isotp_rc_pkg;

  localparam int unsigned IdW   = 29;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned DataW = 64;
  localparam int unsigned RegIdxW = 3;

  // input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_FC   = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_FILTER_VALUE  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_FILTER_MASK   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_TIMEOUT_MS    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_AUTO_FLOW     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_FC_HEADER     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_FC_HEADER_EXT = 3'd5;
  localparam logic [RegIdxW-1:0] REG_FC_LENGTH     = 3'd6;
  localparam logic [RegIdxW-1:0] REG_FC_BYTES      = 3'd7;

  localparam logic [IdW-1:0]   STD_ID_MASK   = 29'h0000_07FF;
  localparam logic [7:0]       PCI_FIRST     = 8'h10;
  localparam logic [7:0]       PCI_CONSEC    = 8'h20;
  localparam logic [7:0]       NEG_RESP_SID  = 8'h7F;
  localparam logic [7:0]       NRC_PENDING   = 8'h78;
  localparam logic [7:0]       FC_BS_DEFAULT = 8'h0A;
  localparam logic [7:0]       FC_BS_MIN     = 8'd10;
  localparam logic [7:0]       FC_BS_MAX     = 8'd127;
  localparam logic [DataW-1:0] FC_DEFAULT    = 64'h0000_0000_000A_0030;
  localparam logic [3:0]       FC_DEFAULT_LEN = 4'd3;

  typedef struct packed {
    logic [IdW-1:0]   filter_value;
    logic [IdW-1:0]   filter_mask;
    logic [TmoW-1:0]  timeout_ms;
    logic             auto_flow;
    logic [IdW-1:0]   fc_header;
    logic             fc_header_ext;
    logic [3:0]       fc_length;
    logic [DataW-1:0] fc_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IdW-1:0]   frame_id;
    logic             frame_ext;
    logic [3:0]       frame_dlc;
    logic [DataW-1:0] frame_data;
    logic [7:0]       request_seq;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   id;
    logic             ext;
    logic [3:0]       dlc;
    logic [DataW-1:0] data;
    logic [7:0]       seq;
    logic             no_data;
    logic             last;
  } res_t;

  // zero every byte at or above position n
  function automatic logic [DataW-1:0] keep_bytes(input logic [DataW-1:0] v,
                                                  input logic [3:0] n);
    logic [DataW-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= n) begin
        r[i*8 +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/isotp_rc_core.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector core
// Exchange state and per-item decision: filter, gap reload, flow control.
// ----------------------------------------------------------------------------
module isotp_rc_core #(
  parameter int unsigned GAP_SINGLE_MS      = 50,
  parameter int unsigned GAP_FIRST_MS       = 100,
  parameter int unsigned GAP_CONSEC_MS      = 100,
  parameter int unsigned DEFAULT_TIMEOUT_MS = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  isotp_rc_pkg::cfg_t  cfg,
  input  logic                fire,
  input  isotp_rc_pkg::item_t item,
  output logic [1:0]          res_cnt,
  output isotp_rc_pkg::res_t  res0,
  output isotp_rc_pkg::res_t  res1
);

  logic        collecting, collecting_next;
  logic        any_seen, any_seen_next;
  logic [15:0] gap, gap_next;
  logic [7:0]  seq, seq_next;
  logic [28:0] req_id, req_id_next;
  logic        req_ext, req_ext_next;

  logic [28:0] id;
  logic [15:0] tmo;
  logic [63:0] data;
  logic [7:0]  b0, b1, b3;
  logic        pass, dlc_ok, is_ff, is_cf, pending, fc;
  logic [15:0] gap_kind, gap_frame;
  logic [3:0]  fc_len;
  logic [63:0] fc_data, fc_raw;
  logic [7:0]  fc_bs;
  logic [28:0] fc_id, fc_id_raw;
  logic        fc_ext;

  assign id     = item.frame_ext ? item.frame_id
                                 : (item.frame_id & isotp_rc_pkg::STD_ID_MASK);
  assign tmo    = (cfg.timeout_ms == '0) ? 16'(DEFAULT_TIMEOUT_MS) : cfg.timeout_ms;
  assign data   = isotp_rc_pkg::keep_bytes(item.frame_data, item.frame_dlc);
  assign b0     = data[7:0];
  assign b1     = data[15:8];
  assign b3     = data[31:24];
  assign dlc_ok = (item.frame_dlc != 4'd0) && (item.frame_dlc <= 4'd8);
  assign pass   = (cfg.filter_mask == '0) ||
                  ((id & cfg.filter_mask) == (cfg.filter_value & cfg.filter_mask));
  assign is_ff  = ((b0 & 8'hF0) == isotp_rc_pkg::PCI_FIRST);
  assign is_cf  = ((b0 & 8'hF0) == isotp_rc_pkg::PCI_CONSEC);
  assign fc     = is_ff && cfg.auto_flow;
  // 7F xx 78: response pending
  assign pending = (item.frame_dlc >= 4'd4) && ((b0 & 8'hF0) == 8'h00) &&
                   (b1 == isotp_rc_pkg::NEG_RESP_SID) && (b3 == isotp_rc_pkg::NRC_PENDING);

  always_comb begin
    if (is_ff) begin
      gap_kind = cfg.auto_flow ? 16'(GAP_CONSEC_MS) : 16'(GAP_FIRST_MS);
    end else if (is_cf) begin
      gap_kind = 16'(GAP_CONSEC_MS);
    end else begin
      gap_kind = 16'(GAP_SINGLE_MS);
    end
    if (pending || (gap_kind > tmo)) begin
      gap_frame = tmo;
    end else begin
      gap_frame = gap_kind;
    end
  end

  // flow-control frame
  always_comb begin
    if (cfg.fc_length == 4'd0) begin
      fc_len = isotp_rc_pkg::FC_DEFAULT_LEN;
      fc_raw = isotp_rc_pkg::FC_DEFAULT;
    end else begin
      fc_len = (cfg.fc_length > 4'd8) ? 4'd8 : cfg.fc_length;
      fc_raw = isotp_rc_pkg::keep_bytes(cfg.fc_bytes, fc_len);
    end
    fc_bs   = fc_raw[23:16];
    fc_data = fc_raw;
    if ((fc_len >= 4'd3) &&
        ((fc_bs < isotp_rc_pkg::FC_BS_MIN) || (fc_bs > isotp_rc_pkg::FC_BS_MAX))) begin
      fc_data[23:16] = isotp_rc_pkg::FC_BS_DEFAULT;
    end
    if (cfg.fc_header != '0) begin
      fc_id_raw = cfg.fc_header;
      fc_ext    = cfg.fc_header_ext;
    end else begin
      if (item.frame_ext) begin
        fc_id_raw = {id[28:16], id[7:0], id[15:8]};
      end else if (id >= 29'd8) begin
        fc_id_raw = id - 29'd8;
      end else begin
        fc_id_raw = req_id;
      end
      fc_ext = req_ext;
    end
    fc_id = fc_ext ? fc_id_raw : (fc_id_raw & isotp_rc_pkg::STD_ID_MASK);
  end

  always_comb begin
    collecting_next = collecting;
    any_seen_next   = any_seen;
    gap_next        = gap;
    seq_next        = seq;
    req_id_next     = req_id;
    req_ext_next    = req_ext;
    res_cnt         = 2'd0;
    res0            = '0;
    res1            = '0;
    res0.seq        = seq;
    res1.seq        = seq;
    case (item.mode)
      isotp_rc_pkg::MODE_START: begin
        req_id_next     = id;
        req_ext_next    = item.frame_ext;
        seq_next        = item.request_seq;
        any_seen_next   = 1'b0;
        collecting_next = 1'b1;
        gap_next        = tmo;
      end
      isotp_rc_pkg::MODE_TICK: begin
        if (collecting) begin
          if (gap > 16'd1) begin
            gap_next = gap - 16'd1;
          end else begin
            gap_next        = '0;
            collecting_next = 1'b0;
            res_cnt         = 2'd1;
            res0.kind       = isotp_rc_pkg::KIND_END;
            res0.no_data    = !any_seen;
            res0.last       = 1'b1;
          end
        end
      end
      isotp_rc_pkg::MODE_FRAME: begin
        if (collecting && dlc_ok && pass) begin
          any_seen_next = 1'b1;
          gap_next      = gap_frame;
          res_cnt       = fc ? 2'd2 : 2'd1;
          res0.kind     = isotp_rc_pkg::KIND_RESP;
          res0.id       = id;
          res0.ext      = item.frame_ext;
          res0.dlc      = item.frame_dlc;
          res0.data     = data;
          res0.last     = !fc;
          res1.kind     = isotp_rc_pkg::KIND_FC;
          res1.id       = fc_id;
          res1.ext      = fc_ext;
          res1.dlc      = fc_len;
          res1.data     = fc_data;
          res1.last     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      any_seen   <= 1'b0;
      gap        <= '0;
      seq        <= '0;
      req_id     <= '0;
      req_ext    <= 1'b0;
    end else if (fire) begin
      collecting <= collecting_next;
      any_seen   <= any_seen_next;
      gap        <= gap_next;
      seq        <= seq_next;
      req_id     <= req_id_next;
      req_ext    <= req_ext_next;
    end
  end

endmodule

// ===== src/isotp_rc_obuf.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector result buffer
// Two-entry result register; loads a whole item's results when it drains.
// ----------------------------------------------------------------------------
module isotp_rc_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [1:0]         load_cnt,
  input  isotp_rc_pkg::res_t load0,
  input  isotp_rc_pkg::res_t load1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output isotp_rc_pkg::res_t head
);

  isotp_rc_pkg::res_t slot0, slot1;
  logic [1:0]         count;
  logic               pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  // empty once this cycle's beat leaves
  assign room      = (count == 2'd0) || ((count == 2'd1) && pop);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= load_cnt;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= load0;
      slot1 <= load1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// ===== src/isotp_response_collector.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector
// Gathers diagnostic replies after a request, answers first frames with flow
// control when auto flow is on and closes the exchange when the reply gap runs out.
// ----------------------------------------------------------------------------
// An input beat is registered, then decided combinationally against the exchange
// state, and its results land in a two-entry output register. An item that gives
// at most one result can be taken every cycle while the receiver takes each
// result; a first frame with auto flow control gives two results, and the next
// item waits in the input register until the second of them leaves the output
// register. Configuration writes are always ready and take effect on the next
// cycle; write them only while the block is idle.
module isotp_response_collector #(
  parameter int unsigned GAP_SINGLE_MS      = 50,
  parameter int unsigned GAP_FIRST_MS       = 100,
  parameter int unsigned GAP_CONSEC_MS      = 100,
  parameter int unsigned DEFAULT_TIMEOUT_MS = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [28:0] frame_id,
  input  logic        frame_ext,
  input  logic [3:0]  frame_dlc,
  input  logic [63:0] frame_data,
  input  logic [7:0]  request_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [28:0] out_id,
  output logic        out_ext,
  output logic [3:0]  out_dlc,
  output logic [63:0] out_data,
  output logic [7:0]  out_seq,
  output logic        no_data,
  output logic        last
);

  isotp_rc_pkg::cfg_t  cfg;
  isotp_rc_pkg::item_t item;
  isotp_rc_pkg::res_t  res0, res1, head;
  logic                item_valid;
  logic                fire, room;
  logic [1:0]          res_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_value  <= '0;
      cfg.filter_mask   <= '0;
      cfg.timeout_ms    <= 16'd1000;
      cfg.auto_flow     <= 1'b1;
      cfg.fc_header     <= '0;
      cfg.fc_header_ext <= 1'b0;
      cfg.fc_length     <= 4'd3;
      cfg.fc_bytes      <= 64'd655408;
    end else if (cfg_valid) begin
      case (cfg_index)
        isotp_rc_pkg::REG_FILTER_VALUE:  cfg.filter_value  <= cfg_data[28:0];
        isotp_rc_pkg::REG_FILTER_MASK:   cfg.filter_mask   <= cfg_data[28:0];
        isotp_rc_pkg::REG_TIMEOUT_MS:    cfg.timeout_ms    <= cfg_data[15:0];
        isotp_rc_pkg::REG_AUTO_FLOW:     cfg.auto_flow     <= cfg_data[0];
        isotp_rc_pkg::REG_FC_HEADER:     cfg.fc_header     <= cfg_data[28:0];
        isotp_rc_pkg::REG_FC_HEADER_EXT: cfg.fc_header_ext <= cfg_data[0];
        isotp_rc_pkg::REG_FC_LENGTH:     cfg.fc_length     <= cfg_data[3:0];
        isotp_rc_pkg::REG_FC_BYTES:      cfg.fc_bytes      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  assign fire     = item_valid && room;
  assign in_ready = !item_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.mode        <= mode;
      item.frame_id    <= frame_id;
      item.frame_ext   <= frame_ext;
      item.frame_dlc   <= frame_dlc;
      item.frame_data  <= frame_data;
      item.request_seq <= request_seq;
    end
  end

  isotp_rc_core #(
    .GAP_SINGLE_MS      (GAP_SINGLE_MS),
    .GAP_FIRST_MS       (GAP_FIRST_MS),
    .GAP_CONSEC_MS      (GAP_CONSEC_MS),
    .DEFAULT_TIMEOUT_MS (DEFAULT_TIMEOUT_MS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .item    (item),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  isotp_rc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_cnt  (res_cnt),
    .load0     (res0),
    .load1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind     = head.kind;
  assign out_id   = head.id;
  assign out_ext  = head.ext;
  assign out_dlc  = head.dlc;
  assign out_data = head.data;
  assign out_seq  = head.seq;
  assign no_data  = head.no_data;
  assign last     = head.last;

endmodule

// ===== src/isotp_rc_checker.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector checker
// Port-level checks on result ordering, end beats and stalled-beat stability, bound to the top level.
// ----------------------------------------------------------------------------
module isotp_rc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [28:0] out_id,
  input logic [3:0]  out_dlc,
  input logic [63:0] out_data,
  input logic        last
);

  logic beat;
  logic fc_owed;

  assign beat = out_valid && out_ready;

  // a response beat without last owes a flow-control beat next
  always_ff @(posedge clk) begin
    if (rst) begin
      fc_owed <= 1'b0;
    end else if (beat) begin
      fc_owed <= (kind == isotp_rc_pkg::KIND_RESP) && !last;
    end
  end

  a_fc_follows_resp: assert property (@(posedge clk) disable iff (rst)
    beat && (kind == isotp_rc_pkg::KIND_FC) |-> fc_owed)
    else $error("flow-control beat without preceding first-frame response");

  a_owed_is_fc: assert property (@(posedge clk) disable iff (rst)
    beat && fc_owed |-> (kind == isotp_rc_pkg::KIND_FC) && last)
    else $error("expected flow-control beat after first-frame response");

  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == isotp_rc_pkg::KIND_END) |->
      last && (out_id == '0) && (out_dlc == 4'd0) && (out_data == '0))
    else $error("end beat with payload or without last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_id)
      && $stable(out_data))
    else $error("result beat changed while stalled");

endmodule

bind isotp_response_collector isotp_rc_checker u_isotp_rc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_id    (out_id),
  .out_dlc   (out_dlc),
  .out_data  (out_data),
  .last      (last)
);

// ===== tb/sv/isotp_response_collector_tb.sv =====
// ----------------------------------------------------------------------------
// ISO-TP response collector testbench
// Drives start, frame and tick beats through exchanges under a series of
// filter, timeout and flow-control settings; a scoreboard predicts every
// response, flow-control and end beat and compares them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module isotp_response_collector_tb;

  localparam int GAP_SINGLE   = 50;
  localparam int GAP_FIRST    = 100;
  localparam int GAP_CONSEC   = 100;
  localparam int TMO_DEFAULT  = 1000;
  localparam int ITEMS_WANTED = 850;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // ------------------------------------------------------------------------
  // exchange predictor and reply checker
  // ------------------------------------------------------------------------
  class rc_scoreboard;
    isotp_rc_pkg::cfg_t cfg;
    bit                 collecting;
    bit                 seen_frame;
    bit                 req_ext;
    bit [15:0]          gap_left;
    bit [7:0]           seq;
    bit [28:0]          req_id;
    isotp_rc_pkg::res_t reply_q[$];
    int                 mismatches;
    int                 n_resp;
    int                 n_fc;
    int                 n_end;

    function new();
      cfg.filter_value  = '0;
      cfg.filter_mask   = '0;
      cfg.timeout_ms    = 16'(TMO_DEFAULT);
      cfg.auto_flow     = 1'b1;
      cfg.fc_header     = '0;
      cfg.fc_header_ext = 1'b0;
      cfg.fc_length     = 4'd3;
      cfg.fc_bytes      = 64'h0000_0000_000A_0030;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        isotp_rc_pkg::REG_FILTER_VALUE:  cfg.filter_value  = v[28:0];
        isotp_rc_pkg::REG_FILTER_MASK:   cfg.filter_mask   = v[28:0];
        isotp_rc_pkg::REG_TIMEOUT_MS:    cfg.timeout_ms    = v[15:0];
        isotp_rc_pkg::REG_AUTO_FLOW:     cfg.auto_flow     = v[0];
        isotp_rc_pkg::REG_FC_HEADER:     cfg.fc_header     = v[28:0];
        isotp_rc_pkg::REG_FC_HEADER_EXT: cfg.fc_header_ext = v[0];
        isotp_rc_pkg::REG_FC_LENGTH:     cfg.fc_length     = v[3:0];
        isotp_rc_pkg::REG_FC_BYTES:      cfg.fc_bytes      = v;
        default: ;
      endcase
    endfunction

    function int eff_tmo();
      return (cfg.timeout_ms != 0) ? int'(cfg.timeout_ms) : TMO_DEFAULT;
    endfunction

    function logic [63:0] clip_payload(logic [63:0] v, int n);
      if (n >= 8) return v;
      return v & ((64'h1 << (8 * n)) - 64'h1);
    endfunction

    function void push(logic [1:0] k, logic [28:0] id, logic x, logic [3:0] dlc,
                       logic [63:0] d, logic nd, logic lst);
      isotp_rc_pkg::res_t r;
      r.kind = k; r.id = id; r.ext = x; r.dlc = dlc; r.data = d;
      r.seq = seq; r.no_data = nd; r.last = lst;
      reply_q.push_back(r);
    endfunction

    // returns 1 when the beat changed state or produced replies
    function bit take_item(isotp_rc_pkg::item_t it);
      logic [28:0] id;
      logic [28:0] fid;
      logic        x;
      logic        fex;
      logic [63:0] d;
      logic [63:0] fd;
      logic [3:0]  pci;
      int          dlc;
      int          len;
      int          gap;
      int          tmo;
      bit          fc;
      x  = it.frame_ext;
      id = x ? it.frame_id : (it.frame_id & isotp_rc_pkg::STD_ID_MASK);
      case (it.mode)
        isotp_rc_pkg::MODE_START: begin
          req_id     = id;
          req_ext    = x;
          seq        = it.request_seq;
          seen_frame = 1'b0;
          collecting = 1'b1;
          gap_left   = 16'(eff_tmo());
          return 1'b1;
        end
        isotp_rc_pkg::MODE_TICK: begin
          if (!collecting) return 1'b0;
          if (gap_left > 1) begin
            gap_left--;
            return 1'b1;
          end
          gap_left   = '0;
          collecting = 1'b0;
          push(isotp_rc_pkg::KIND_END, '0, 1'b0, 4'd0, '0, !seen_frame, 1'b1);
          return 1'b1;
        end
        isotp_rc_pkg::MODE_FRAME: begin
          dlc = int'(it.frame_dlc);
          if (!collecting || dlc == 0 || dlc > 8) return 1'b0;
          if (cfg.filter_mask != 0 &&
              (id & cfg.filter_mask) != (cfg.filter_value & cfg.filter_mask)) return 1'b0;
          d   = clip_payload(it.frame_data, dlc);
          pci = d[7:4];
          seen_frame = 1'b1;
          tmo = eff_tmo();
          fc  = 1'b0;
          gap = GAP_SINGLE;
          if (pci == isotp_rc_pkg::PCI_FIRST[7:4]) begin
            if (cfg.auto_flow) begin
              fc  = 1'b1;
              gap = GAP_CONSEC;
            end else begin
              gap = GAP_FIRST;
            end
          end else if (pci == isotp_rc_pkg::PCI_CONSEC[7:4]) begin
            gap = GAP_CONSEC;
          end
          if (gap > tmo) gap = tmo;
          // response pending stretches the gap to the whole timeout
          if (dlc >= 4 && pci == 4'h0 && d[15:8] == isotp_rc_pkg::NEG_RESP_SID &&
              d[31:24] == isotp_rc_pkg::NRC_PENDING)
            gap = tmo;
          gap_left = 16'(gap);
          push(isotp_rc_pkg::KIND_RESP, id, x, 4'(dlc), d, 1'b0, !fc);
          if (fc) begin
            len = int'(cfg.fc_length);
            if (len == 0) begin
              len = int'(isotp_rc_pkg::FC_DEFAULT_LEN);
              fd  = isotp_rc_pkg::FC_DEFAULT;
            end else begin
              if (len > 8) len = 8;
              fd = clip_payload(cfg.fc_bytes, len);
            end
            if (len >= 3 && (fd[23:16] < isotp_rc_pkg::FC_BS_MIN ||
                             fd[23:16] > isotp_rc_pkg::FC_BS_MAX))
              fd[23:16] = isotp_rc_pkg::FC_BS_DEFAULT;
            if (cfg.fc_header != 0) begin
              fid = cfg.fc_header;
              fex = cfg.fc_header_ext;
            end else begin
              if (x) fid = {id[28:16], id[7:0], id[15:8]};
              else   fid = (id >= 8) ? id - 29'd8 : req_id;
              fex = req_ext;
            end
            if (!fex) fid = fid & isotp_rc_pkg::STD_ID_MASK;
            push(isotp_rc_pkg::KIND_FC, fid, fex, 4'(len), fd, 1'b0, 1'b1);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function string show(isotp_rc_pkg::res_t r);
      return $sformatf("kind=%0d id=%h ext=%0d dlc=%0d data=%h seq=%h no_data=%0d last=%0d",
                       r.kind, r.id, r.ext, r.dlc, r.data, r.seq, r.no_data, r.last);
    endfunction

    function void check_result(isotp_rc_pkg::res_t got);
      isotp_rc_pkg::res_t want;
      bit                 bad;
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: reply beat with nothing expected: %s", $realtime, show(got));
        return;
      end
      want = reply_q.pop_front();
      case (want.kind)
        isotp_rc_pkg::KIND_RESP: n_resp++;
        isotp_rc_pkg::KIND_FC:   n_fc++;
        default:                 n_end++;
      endcase
      bad = (got.kind !== want.kind) || (got.id !== want.id) || (got.ext !== want.ext) ||
            (got.dlc !== want.dlc) || (got.data !== want.data) || (got.seq !== want.seq) ||
            (got.no_data !== want.no_data) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: reply beat mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // signals and block
  // ------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [28:0] frame_id;
  logic        frame_ext;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_data;
  logic [7:0]  request_seq;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [28:0] out_id;
  logic        out_ext;
  logic [3:0]  out_dlc;
  logic [63:0] out_data;
  logic [7:0]  out_seq;
  logic        no_data;
  logic        last;

  rc_scoreboard sb = new();

  int items_taken   = 0;
  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int phases_run    = 0;

  isotp_response_collector #(
    .GAP_SINGLE_MS      (GAP_SINGLE),
    .GAP_FIRST_MS       (GAP_FIRST),
    .GAP_CONSEC_MS      (GAP_CONSEC),
    .DEFAULT_TIMEOUT_MS (TMO_DEFAULT)
  ) dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .frame_id, .frame_ext, .frame_dlc, .frame_data,
    .request_seq,
    .out_valid, .out_ready, .kind, .out_id, .out_ext, .out_dlc, .out_data, .out_seq,
    .no_data, .last
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting on the collector");
    $display("Mismatches found");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // replies are checked before the same edge's input beat is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(isotp_rc_pkg::res_t'{kind, out_id, out_ext, out_dlc, out_data,
                                             out_seq, no_data, last});
      if (in_valid && in_ready)
        if (sb.take_item(isotp_rc_pkg::item_t'{mode, frame_id, frame_ext, frame_dlc,
                                               frame_data, request_seq}))
          items_taken++;
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  function automatic isotp_rc_pkg::item_t mk_item(logic [1:0] m, logic [28:0] id, logic x,
                                                  logic [3:0] dlc, logic [63:0] d,
                                                  logic [7:0] s);
    isotp_rc_pkg::item_t it;
    it.mode = m; it.frame_id = id; it.frame_ext = x;
    it.frame_dlc = dlc; it.frame_data = d; it.request_seq = s;
    return it;
  endfunction

  task automatic put_item(input isotp_rc_pkg::item_t it);
    while ($urandom_range(99) < snd_idle_pct) @(negedge clk);
    in_valid    = 1'b1;
    mode        = it.mode;
    frame_id    = it.frame_id;
    frame_ext   = it.frame_ext;
    frame_dlc   = it.frame_dlc;
    frame_data  = it.frame_data;
    request_seq = it.request_seq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every reply, then for beats that give none to clear the pipe
  task automatic settle();
    while (sb.reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // frame that passes the current filter, with a random PCI flavor
  function automatic isotp_rc_pkg::item_t mk_reply();
    logic [28:0] id;
    logic [28:0] m;
    logic [28:0] v;
    logic        x;
    logic [3:0]  dlc;
    logic [63:0] d;
    m   = sb.cfg.filter_mask;
    v   = sb.cfg.filter_value;
    id  = 29'($urandom());
    if ($urandom_range(7) == 0) id[10:3] = 8'h00;
    id  = (v & m) | (id & ~m);
    // filter bits above the standard range need an extended ID
    x   = (((v & m) >> 11) != 0) ? 1'b1 : 1'($urandom_range(1));
    dlc = 4'($urandom_range(1, 8));
    d   = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0, 1, 2: d[7:4] = 4'h0;
      3, 4:    d[7:4] = isotp_rc_pkg::PCI_FIRST[7:4];
      5, 6:    d[7:4] = isotp_rc_pkg::PCI_CONSEC[7:4];
      7: begin
        dlc = 4'($urandom_range(4, 8));
        d[7:4] = 4'h0; d[15:8] = isotp_rc_pkg::NEG_RESP_SID;
        d[31:24] = isotp_rc_pkg::NRC_PENDING;
      end
      8: begin
        // pending pattern cut short by the DLC
        dlc = 4'($urandom_range(1, 3));
        d[7:4] = 4'h0; d[15:8] = isotp_rc_pkg::NEG_RESP_SID;
        d[31:24] = isotp_rc_pkg::NRC_PENDING;
      end
      default: ;
    endcase
    return mk_item(isotp_rc_pkg::MODE_FRAME, id, x, dlc, d, 8'($urandom()));
  endfunction

  function automatic isotp_rc_pkg::item_t mk_noise();
    isotp_rc_pkg::item_t it;
    logic [28:0]         m;
    it = mk_reply();
    m  = sb.cfg.filter_mask;
    case ($urandom_range(3))
      0: it.frame_dlc = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
      1: it.frame_id  = it.frame_id ^ (m & (~m + 29'd1));
      2: it.mode      = MODE_UNUSED;
      default: it.mode = isotp_rc_pkg::MODE_TICK;
    endcase
    return it;
  endfunction

  task automatic run_exchange();
    int n_frames;
    put_item(mk_item(isotp_rc_pkg::MODE_START, 29'($urandom()), 1'($urandom_range(1)),
                     4'($urandom()), {$urandom(), $urandom()}, 8'($urandom())));
    n_frames = $urandom_range(0, 5);
    repeat (n_frames) begin
      if ($urandom_range(9) == 0) put_item(mk_noise());
      put_item(mk_reply());
      if ($urandom_range(3) == 0)
        put_item(mk_item(isotp_rc_pkg::MODE_TICK, '0, 1'b0, 4'd0, '0, 8'd0));
    end
    // some exchanges are cut off by the next start
    if ($urandom_range(15) == 0 || sb.gap_left > 160) return;
    while (sb.collecting)
      put_item(mk_item(isotp_rc_pkg::MODE_TICK, '0, 1'b0, 4'd0, '0, 8'd0));
    if ($urandom_range(4) == 0) put_item(mk_noise());
  endtask

  task automatic set_phase(input int p);
    logic [28:0] fv;
    logic [28:0] fm;
    logic [15:0] tmo;
    logic        af;
    logic [28:0] hdr;
    logic        hx;
    logic [3:0]  flen;
    logic [63:0] fb;
    fv = '0; fm = '0; af = 1'b1; hdr = '0; hx = 1'b0;
    fb = {$urandom(), $urandom()};
    case (p)
      0: begin tmo = 16'd4; flen = 4'd0; end
      1: begin
        fv = 29'h7E8; fm = 29'h7F8; tmo = 16'd1; hdr = 29'h7E0;
        flen = 4'd8; fb = '1;
      end
      2: begin fv = 29'h18DAF100; fm = 29'h1FFFFF00; tmo = 16'd7; af = 1'b0; flen = 4'd3; end
      3: begin
        fv = '1; fm = '1; tmo = 16'd2; hdr = '1; hx = 1'b1; flen = 4'd15; fb = '0;
      end
      4: begin tmo = 16'd120; flen = 4'd5; end
      5: begin tmo = 16'd0; flen = 4'd1; end
      6: begin tmo = 16'hFFFF; flen = 4'd2; hx = 1'b1; end
      default: begin
        fv   = 29'($urandom());
        fm   = 29'($urandom()) & (($urandom_range(1) != 0) ? 29'h7FF : 29'h1FFFFFFF);
        tmo  = 16'($urandom_range(1, 10));
        af   = 1'($urandom_range(1));
        hdr  = ($urandom_range(1) != 0) ? 29'd0 : 29'($urandom());
        hx   = 1'($urandom_range(1));
        flen = 4'($urandom_range(0, 15));
      end
    endcase
    settle();
    write_reg(isotp_rc_pkg::REG_FILTER_VALUE, 64'(fv));
    write_reg(isotp_rc_pkg::REG_FILTER_MASK, 64'(fm));
    write_reg(isotp_rc_pkg::REG_TIMEOUT_MS, 64'(tmo));
    write_reg(isotp_rc_pkg::REG_AUTO_FLOW, 64'(af));
    write_reg(isotp_rc_pkg::REG_FC_HEADER, 64'(hdr));
    write_reg(isotp_rc_pkg::REG_FC_HEADER_EXT, 64'(hx));
    write_reg(isotp_rc_pkg::REG_FC_LENGTH, 64'(flen));
    write_reg(isotp_rc_pkg::REG_FC_BYTES, fb);
    phases_run++;
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  initial begin
    int                  phase_no;
    int                  p;
    int                  guard;
    bit                  hold_done;
    isotp_rc_pkg::item_t tick;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; mode = isotp_rc_pkg::MODE_START; frame_id = '0; frame_ext = 1'b0;
    frame_dlc = '0; frame_data = '0; request_seq = '0;
    tick = mk_item(isotp_rc_pkg::MODE_TICK, '0, 1'b0, 4'd0, '0, 8'd0);
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    snd_idle_pct = 36;
    rcv_idle_pct = 49;

    // directed part, reset settings first
    put_item(tick);
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd8, '1, 8'h00));
    put_item(mk_item(MODE_UNUSED, '1, 1'b1, 4'hF, '1, 8'hFF));
    put_item(mk_item(isotp_rc_pkg::MODE_START, 29'h1FFFF7E0, 1'b0, 4'd0, '0, 8'hA5));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd0, '1, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd9, '1, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd15, '1, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd8, '1, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd8,
                     64'h1122_3344_5566_0210, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h003, 1'b0, 4'd8,
                     64'h0000_0000_0000_0814, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h18DAF110, 1'b1, 4'd2,
                     64'h0000_0000_0000_0510, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd8,
                     64'hAAAA_AAAA_AAAA_AA21, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd4,
                     64'hFFFF_FFFF_7822_7F03, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd3,
                     64'hFFFF_FFFF_7822_7F03, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_START, 29'h1FFFFFFF, 1'b1, 4'd0, '0, 8'h00));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h0, 1'b1, 4'd1,
                     64'h0000_0000_0000_FF10, 8'h00));
    settle();
    write_reg(isotp_rc_pkg::REG_TIMEOUT_MS, 64'd1);
    put_item(mk_item(isotp_rc_pkg::MODE_START, 29'h7DF, 1'b0, 4'd0, '0, 8'h5A));
    put_item(tick);
    put_item(mk_item(isotp_rc_pkg::MODE_START, 29'h7E0, 1'b0, 4'd0, '0, 8'hFF));
    put_item(mk_item(isotp_rc_pkg::MODE_FRAME, 29'h7E8, 1'b0, 4'd1, 64'h0, 8'h00));
    put_item(tick);
    put_item(tick);

    // random exchanges across settings
    phase_no = 0;
    while (items_taken < ITEMS_WANTED) begin
      if (phase_no < 8) begin
        p = phase_no;
      end else begin
        case ($urandom_range(5))
          0: p = 0;
          1: p = 1;
          2: p = 2;
          3: p = 3;
          default: p = 7;
        endcase
      end
      set_phase(p);
      repeat ((p >= 4 && p <= 6) ? 3 : 10) begin
        if (items_taken < ITEMS_WANTED / 3) begin
          snd_idle_pct = 36; rcv_idle_pct = 49;
        end else if (items_taken < 2 * ITEMS_WANTED / 3) begin
          snd_idle_pct = 49; rcv_idle_pct = 36;
        end else begin
          snd_idle_pct = 0; rcv_idle_pct = 0;
        end
        // long receiver stall while the sender keeps going
        if (!hold_done && items_taken >= 300) begin
          hold_done = 1'b1;
          hold_requests++;
        end
        if (items_taken < ITEMS_WANTED) run_exchange();
      end
      phase_no++;
    end

    guard = 0;
    while (sb.reply_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (sb.reply_q.size() != 0) begin
      $display("%0d expected reply beats never arrived", sb.reply_q.size());
      sb.mismatches += sb.reply_q.size();
    end

    $display("Run covered %0d effective input beats over %0d register settings",
             items_taken, phases_run + 1);
    $display("Replies checked: %0d responses, %0d flow-control frames, %0d exchange ends",
             sb.n_resp, sb.n_fc, sb.n_end);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
